@@ rtl/core/fte_pkg.sv @@
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types and constants for the binary indexed tree engine: field
// widths, operation codes, walk kinds, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fte_pkg;

  // Fixed field widths of one request beat and one response beat.
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned BOUND_W = 11;
  localparam int unsigned VAL_W   = 64;

  // Operation codes carried in the action field.
  typedef enum logic [ACT_W-1:0] {
    OP_ADD = 2'd0,
    OP_SET = 2'd1,
    OP_SUM = 2'd2
  } op_e;

  // Kind of tree walk the datapath runs.
  typedef enum logic [1:0] {
    WK_PFX_ADD = 2'd0,  // prefix walk, node values added to the accumulator
    WK_PFX_SUB = 2'd1,  // prefix walk, node values subtracted
    WK_UPD     = 2'd2   // update walk, delta added to each covering node
  } walk_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_DECODE = 3'd2,
    ST_WALK_A = 3'd3,
    ST_WALK_B = 3'd4,
    ST_UPDATE = 3'd5,
    ST_FINISH = 3'd6
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  clr;    // write zero to the next entry of the clearing pass
    logic  load;   // capture the request beat
    logic  start;  // start a walk of the given kind
    walk_e kind;
    logic  emit;   // place the result in the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             clr_last;   // clearing pass is on its last entry
    logic             walk_done;  // no walk step issued or in flight
    logic             err;        // captured request is out of range
    logic [ACT_W-1:0] op;         // captured action code
    logic             out_busy;   // output register holds a beat not taken this cycle
  } dp_status_t;

endpackage

@@ rtl/core/fte_if.sv @@
// ----------------------------------------------------------------------------
// fte_if
// Valid/ready channels of the binary indexed tree engine: the request
// channel carrying one operation and the response channel carrying its result.
// ----------------------------------------------------------------------------
interface fte_req_if;
  import fte_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic [IDX_W-1:0]          index;
  logic [BOUND_W-1:0]        left;
  logic [BOUND_W-1:0]        right;
  logic signed [VAL_W-1:0]   value;

  modport source (output valid, action, index, left, right, value, input ready);
  modport sink   (input valid, action, index, left, right, value, output ready);
endinterface

interface fte_rsp_if;
  import fte_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VAL_W-1:0]   total;
  logic                      error;

  modport source (output valid, total, error, input ready);
  modport sink   (input valid, total, error, output ready);
endinterface

@@ rtl/core/fenwick_tree_engine_top.sv @@
// One operation at a time: a new request is taken once the controller is back in idle after
// the response is loaded, while that response may still wait for its reader.
// After reset a clearing pass writes zero to all TABLE_SIZE nodes, one per cycle,
// and no request is accepted until it is over.
// ----------------------------------------------------------------------------
// fenwick_tree_engine_top
// Binary indexed tree over signed 64-bit entries with add, set and range sum
// operations, built from a sequencing controller and a memory datapath.
// ----------------------------------------------------------------------------
module fenwick_tree_engine_top #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fte_req_if.sink   req_i,
  fte_rsp_if.source rsp_o
);
  import fte_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  fte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Node memory, walk logic and result register.
  fte_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .action_i    (req_i.action),
    .index_i     (req_i.index),
    .left_i      (req_i.left),
    .right_i     (req_i.right),
    .value_i     (req_i.value),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .total_o     (rsp_o.total),
    .error_o     (rsp_o.error)
  );

endmodule

@@ rtl/core/fte_ctrl.sv @@
// ----------------------------------------------------------------------------
// fte_ctrl
// Controller of the binary indexed tree engine. Runs the clearing pass after
// reset, then sequences each operation as a series of tree walks issued to
// the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module fte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fte_pkg::dp_status_t status_i,
  output fte_pkg::ctrl_cmd_t  cmd_o
);
  import fte_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = WK_PFX_ADD;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (status_i.err) begin
          state_d = ST_FINISH;
        end else if (status_i.op == OP_ADD) begin
          cmd_o.start = 1'b1;
          cmd_o.kind  = WK_UPD;
          state_d     = ST_UPDATE;
        end else begin
          // Set and range sum both begin with the upper prefix walk.
          cmd_o.start = 1'b1;
          cmd_o.kind  = WK_PFX_ADD;
          state_d     = ST_WALK_A;
        end
      end

      ST_WALK_A: begin
        if (status_i.walk_done) begin
          cmd_o.start = 1'b1;
          cmd_o.kind  = WK_PFX_SUB;
          state_d     = ST_WALK_B;
        end
      end

      ST_WALK_B: begin
        if (status_i.walk_done) begin
          if (status_i.op == OP_SET) begin
            cmd_o.start = 1'b1;
            cmd_o.kind  = WK_UPD;
            state_d     = ST_UPDATE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_UPDATE: begin
        if (status_i.walk_done) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/fte_datapath.sv @@
// ----------------------------------------------------------------------------
// fte_datapath
// Datapath of the binary indexed tree engine: the node memory, the walk
// counter, the prefix accumulator, the update delta and the output register.
// Walk steps are pipelined: a node is read every cycle and its data is
// accumulated, or written back with the delta added, in the cycle after.
// ----------------------------------------------------------------------------
module fte_datapath #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fte_pkg::ctrl_cmd_t                   cmd_i,
  output fte_pkg::dp_status_t                  status_o,
  input  logic [fte_pkg::ACT_W-1:0]            action_i,
  input  logic [fte_pkg::IDX_W-1:0]            index_i,
  input  logic [fte_pkg::BOUND_W-1:0]          left_i,
  input  logic [fte_pkg::BOUND_W-1:0]          right_i,
  input  logic signed [fte_pkg::VAL_W-1:0]     value_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [fte_pkg::VAL_W-1:0]     total_o,
  output logic                                 error_o
);
  import fte_pkg::*;

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  // Node numbers run 1..TABLE_SIZE; one more bit holds the step past the end.
  localparam int unsigned NW = $clog2(TABLE_SIZE + 1) + 1;
  localparam logic [31:0] TS32 = 32'(TABLE_SIZE);

  // Captured request.
  logic [ACT_W-1:0]   op_q;
  logic [IDX_W-1:0]   index_q;
  logic [BOUND_W-1:0] left_q;
  logic [BOUND_W-1:0] right_q;
  logic [VAL_W-1:0]   value_q;
  logic               err_q;
  logic               in_err;

  // Walk state.
  walk_e              mode_q;
  logic [NW-1:0]      cnt_q, cnt_d;
  logic               active_q, active_d;
  logic               pend_q;
  logic [AW-1:0]      waddr_q;
  logic [VAL_W-1:0]   acc_q;
  logic [VAL_W-1:0]   delta_q;
  logic [NW-1:0]      cnt_m1;
  logic [NW-1:0]      low_bit;
  logic [NW-1:0]      start_cnt;

  // Node memory ports.
  logic [VAL_W-1:0]   tree_mem [TABLE_SIZE];
  logic [AW-1:0]      clr_q;
  logic [AW-1:0]      raddr;
  logic [VAL_W-1:0]   rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;

  // Output register.
  logic               out_valid_q;
  logic [VAL_W-1:0]   total_q;
  logic               error_q;

  // Range check of the incoming request.
  always_comb begin
    if (action_i == OP_ADD || action_i == OP_SET) begin
      in_err = {22'd0, index_i} >= TS32;
    end else if (action_i == OP_SUM) begin
      in_err = (left_i > right_i) || ({21'd0, right_i} > TS32);
    end else begin
      in_err = 1'b1;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= action_i;
      index_q <= index_i;
      left_q  <= left_i;
      right_q <= right_i;
      value_q <= value_i;
      err_q   <= in_err;
    end
  end

  // Starting node of each walk kind.
  always_comb begin
    unique case (cmd_i.kind)
      WK_PFX_ADD: begin
        start_cnt = (op_q == OP_SET) ? NW'({1'b0, index_q} + 11'd1) : NW'(right_q);
      end
      WK_PFX_SUB: begin
        start_cnt = (op_q == OP_SET) ? NW'(index_q) : NW'(left_q);
      end
      default: begin
        start_cnt = NW'({1'b0, index_q} + 11'd1);
      end
    endcase
  end

  // Next node of the running walk.
  assign cnt_m1  = cnt_q - NW'(1);
  assign low_bit = cnt_q & (~cnt_q + NW'(1));
  assign raddr   = cnt_m1[AW-1:0];

  always_comb begin
    cnt_d    = cnt_q;
    active_d = active_q;
    if (cmd_i.start) begin
      cnt_d    = start_cnt;
      active_d = (cmd_i.kind == WK_UPD) ? 1'b1 : (start_cnt != '0);
    end else if (active_q) begin
      if (mode_q == WK_UPD) begin
        cnt_d    = cnt_q + low_bit;
        active_d = cnt_d <= NW'(TABLE_SIZE);
      end else begin
        cnt_d    = cnt_q & cnt_m1;
        active_d = cnt_d != '0;
      end
    end
  end

  // Walk control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      mode_q   <= WK_PFX_ADD;
      clr_q    <= '0;
    end else begin
      active_q <= active_d;
      pend_q   <= active_q && !cmd_i.start;
      if (cmd_i.start) begin
        mode_q <= cmd_i.kind;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Walk payload: counter, write-back address, accumulator and delta.
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    waddr_q <= raddr;
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (pend_q && mode_q == WK_PFX_ADD) begin
      acc_q <= acc_q + rdata_q;
    end else if (pend_q && mode_q == WK_PFX_SUB) begin
      acc_q <= acc_q - rdata_q;
    end
    if (cmd_i.start && cmd_i.kind == WK_UPD) begin
      delta_q <= (op_q == OP_SET) ? value_q - acc_q : value_q;
    end
  end

  // Memory write port: clearing pass or update write-back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr_q;
    mem_wdata = rdata_q + delta_q;
    if (cmd_i.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (pend_q && mode_q == WK_UPD) begin
      mem_we = 1'b1;
    end
  end

  // Node memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q) begin
      rdata_q <= tree_mem[raddr];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      error_q <= err_q;
      total_q <= (!err_q && op_q == OP_SUM) ? acc_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_o     = total_q;
  assign error_o     = error_q;

  // Status toward the controller.
  assign status_o.clr_last  = clr_q == AW'(TABLE_SIZE - 1);
  assign status_o.walk_done = !active_q && !pend_q;
  assign status_o.err       = err_q;
  assign status_o.op        = op_q;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

@@ verif/fenwick_tree_engine_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_tree_engine_top_test
// Self-checking bench for the binary indexed tree engine. A short table of
// directed operations covers the table ends, value extremes, wrap-around,
// empty and out-of-range intervals and the unknown action. After it come
// random add, set and range-sum traffic under several idling patterns and
// one long response hold-off. Every response beat is compared in order against
// a flat per-position model of the table or a hand-written expectation.
// ----------------------------------------------------------------------------
module fenwick_tree_engine_top_test;
  import fte_pkg::*;

  localparam int unsigned      TABLE_SIZE     = 1024;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN    = 2'd3;
  localparam int unsigned      N_DIRECTED     = 25;
  localparam int unsigned      RAND_PER_PHASE = 282;
  localparam int unsigned      N_PHASES       = 4;
  localparam int unsigned      HOLD_CYCLES    = 400;
  localparam int unsigned      TAIL_CYCLES    = 150;
  localparam int unsigned      PRINT_CAP      = 100;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic signed [VAL_W-1:0] VAL_NEG = 64'hFFFF_FFFF_FFFF_FFFF;

  // One request beat, with an optional hand-written expectation.
  typedef struct {
    logic [ACT_W-1:0]        act;
    logic [IDX_W-1:0]        idx;
    logic [BOUND_W-1:0]      lo;
    logic [BOUND_W-1:0]      hi;
    logic signed [VAL_W-1:0] val;
    bit                      chk;
    logic signed [VAL_W-1:0] x_total;
    bit                      x_err;
  } op_beat_t;

  typedef struct {
    logic signed [VAL_W-1:0] total;
    logic                    error;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fte_req_if req_bus ();
  fte_rsp_if rsp_bus ();

  fenwick_tree_engine_top #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Value held at each table position, as the engine should see it.
  logic [VAL_W-1:0] position_vals [TABLE_SIZE];

  op_beat_t    req_backlog [$];
  outcome_t    pending_results [$];
  int unsigned mismatch_cnt   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_rsp;

  // Directed operations. Indexes cannot leave the table with a 10-bit field,
  // so only the interval and the action can be out of range here.
  op_beat_t directed_ops [N_DIRECTED] = '{
    // Whole table and empty intervals straight after the clearing pass.
    '{OP_SUM, 10'd0, 11'd0, 11'd1024, 64'd0, 1'b1, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd0, 11'd0, VAL_NEG, 1'b1, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd1024, 11'd1024, 64'd0, 1'b1, 64'd0, 1'b0},
    // Extremes at both ends of the table, then a wrapping sum.
    '{OP_ADD, 10'd0, 11'd0, 11'd0, VAL_MAX, 1'b1, 64'd0, 1'b0},
    '{OP_ADD, 10'd1023, 11'd0, 11'd0, VAL_MIN, 1'b1, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd0, 11'd1024, 64'd0, 1'b0, 64'd0, 1'b0},
    '{OP_ADD, 10'd0, 11'd0, 11'd0, 64'd1, 1'b1, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd0, 11'd1, 64'd0, 1'b0, 64'd0, 1'b0},
    // Set over an untouched entry, over a written one and back to zero.
    '{OP_SET, 10'd512, 11'd0, 11'd0, VAL_NEG, 1'b1, 64'd0, 1'b0},
    '{OP_SET, 10'd1023, 11'd0, 11'd0, 64'd5, 1'b1, 64'd0, 1'b0},
    '{OP_SET, 10'd0, 11'd0, 11'd0, 64'd0, 1'b1, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd512, 11'd513, 64'd0, 1'b0, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd1, 11'd1023, 64'd0, 1'b0, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd0, 11'd1024, 64'd0, 1'b0, 64'd0, 1'b0},
    // Reversed and oversized intervals, then the unknown action.
    '{OP_SUM, 10'd0, 11'd5, 11'd4, 64'd0, 1'b1, 64'd0, 1'b1},
    '{OP_SUM, 10'd0, 11'd0, 11'd1025, 64'd0, 1'b1, 64'd0, 1'b1},
    '{OP_SUM, 10'd0, 11'd2047, 11'd2047, 64'd0, 1'b1, 64'd0, 1'b1},
    '{OP_SUM, 10'd0, 11'd1024, 11'd0, 64'd0, 1'b1, 64'd0, 1'b1},
    '{ACT_UNKNOWN, 10'd1023, 11'd2047, 11'd2047, VAL_NEG, 1'b1, 64'd0, 1'b1},
    // Alternating bit patterns in index and value.
    '{OP_ADD, 10'h2AA, 11'd0, 11'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'd0, 1'b0},
    '{OP_SET, 10'h155, 11'd0, 11'd0, 64'h5555_5555_5555_5555, 1'b1, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'h155, 11'h2AA, 64'd0, 1'b0, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd1023, 11'd1024, 64'd0, 1'b0, 64'd0, 1'b0},
    '{OP_SET, 10'd1023, 11'd0, 11'd0, VAL_MIN, 1'b1, 64'd0, 1'b0},
    '{OP_SUM, 10'd0, 11'd0, 11'd1024, 64'd0, 1'b0, 64'd0, 1'b0}
  };

  // Applies one operation to the position table and returns its result.
  function automatic outcome_t predict_outcome(op_beat_t b);
    outcome_t         o;
    logic [VAL_W-1:0] acc;
    o.total = '0;
    o.error = 1'b0;
    acc     = '0;
    if (b.act == OP_ADD || b.act == OP_SET) begin
      if (b.idx >= TABLE_SIZE) begin
        o.error = 1'b1;
      end else if (b.act == OP_ADD) begin
        position_vals[b.idx] = position_vals[b.idx] + b.val;
      end else begin
        position_vals[b.idx] = b.val;
      end
    end else if (b.act == OP_SUM) begin
      if (b.lo > b.hi || b.hi > TABLE_SIZE) begin
        o.error = 1'b1;
      end else begin
        for (int p = b.lo; p < b.hi; p++) acc = acc + position_vals[p];
        o.total = acc;
      end
    end else begin
      o.error = 1'b1;
    end
    return o;
  endfunction

  // Called once per accepted request beat.
  function automatic void record_request(op_beat_t b);
    outcome_t o;
    o = predict_outcome(b);
    if (b.chk) begin
      o.total = b.x_total;
      o.error = b.x_err;
    end
    pending_results.push_back(o);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    int small_val;
    small_val = int'($urandom_range(200)) - 100;
    case ($urandom_range(3))
      0: return small_val;
      1: begin
        case ($urandom_range(3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return VAL_NEG;
          default: return '0;
        endcase
      end
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Mostly well-formed updates and sums on a few hot positions and on the
  // whole table, with a share of bad intervals and unknown actions.
  function automatic op_beat_t rand_op();
    op_beat_t    b;
    int unsigned pick;
    int unsigned a0;
    int unsigned a1;
    pick    = $urandom_range(99);
    b.chk   = 1'b0;
    b.x_total = '0;
    b.x_err = 1'b0;
    b.val   = rand_value();
    b.lo    = BOUND_W'($urandom_range(2047));
    b.hi    = BOUND_W'($urandom_range(2047));
    case ($urandom_range(9))
      0, 1, 2, 3: b.idx = IDX_W'($urandom_range(15));
      4:          b.idx = IDX_W'(1023 - $urandom_range(15));
      default:    b.idx = IDX_W'($urandom_range(1023));
    endcase
    if (pick < 30) begin
      b.act = OP_ADD;
    end else if (pick < 55) begin
      b.act = OP_SET;
    end else if (pick < 90) begin
      b.act = OP_SUM;
      a0 = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(TABLE_SIZE);
      a1 = $urandom_range(TABLE_SIZE);
      b.lo = BOUND_W'((a0 < a1) ? a0 : a1);
      b.hi = BOUND_W'((a0 < a1) ? a1 : a0);
    end else if (pick < 97) begin
      // Bad interval: reversed, or ending past the table.
      b.act = OP_SUM;
      if ($urandom_range(1) == 0) begin
        b.hi = BOUND_W'($urandom_range(2046));
        b.lo = BOUND_W'($urandom_range(2047, b.hi + 1));
      end else begin
        b.hi = BOUND_W'($urandom_range(2047, TABLE_SIZE + 1));
      end
    end else begin
      b.act = ACT_UNKNOWN;
    end
    return b;
  endfunction

  // Request side: a beat stays offered until it is taken.
  always @(posedge clk) begin
    bit offer;
    offer = 1'b0;
    if (rst_n) begin
      if (req_bus.valid && req_bus.ready) record_request(req_backlog.pop_front());
      if (req_backlog.size() != 0) begin
        offer = (req_bus.valid && !req_bus.ready) ||
                ($urandom_range(99) >= send_idle_pct);
      end
      if (offer) begin
        req_bus.action <= req_backlog[0].act;
        req_bus.index  <= req_backlog[0].idx;
        req_bus.left   <= req_backlog[0].lo;
        req_bus.right  <= req_backlog[0].hi;
        req_bus.value  <= req_backlog[0].val;
      end
    end
    req_bus.valid <= offer;
  end

  // Response side: compare each beat with the oldest expected result.
  always @(posedge clk) begin
    outcome_t want;
    bit       take;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing expected (total %0d error %0b)",
                                  rsp_bus.total, rsp_bus.error));
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.total !== want.total)
          report_mismatch($sformatf("total %0d, expected %0d", rsp_bus.total, want.total));
        if (rsp_bus.error !== want.error)
          report_mismatch($sformatf("error %0b, expected %0b", rsp_bus.error, want.error));
      end
    end
    take = rst_n && !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
    rsp_bus.ready <= take;
  end

  task automatic wait_drain();
    while (req_backlog.size() != 0 || pending_results.size() != 0) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    req_bus.valid  = 1'b0;
    req_bus.action = '0;
    req_bus.index  = '0;
    req_bus.left   = '0;
    req_bus.right  = '0;
    req_bus.value  = '0;
    rsp_bus.ready  = 1'b0;
    hold_rsp       = 1'b0;
    foreach (position_vals[p]) position_vals[p] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) req_backlog.push_back(directed_ops[i]);
    wait_drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
      // Long response hold-off while requests keep coming, to back up the engine.
      if (ph == 0) begin
        fork
          begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rsp <= 1'b0;
          end
        join_none
      end
      repeat (RAND_PER_PHASE) req_backlog.push_back(rand_op());
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_cnt == 0) begin
      $display("PASS fenwick_tree_engine_top");
    end else begin
      $display("FAIL fenwick_tree_engine_top");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin
    #2_000_000;
    $display("[%0t] watchdog expired", $time);
    $display("FAIL fenwick_tree_engine_top");
    $finish;
  end

endmodule

@@ fenwick_tree_engine_top.f @@
rtl/core/fte_pkg.sv
rtl/core/fte_if.sv
rtl/core/fte_ctrl.sv
rtl/core/fte_datapath.sv
rtl/core/fenwick_tree_engine_top.sv
verif/fenwick_tree_engine_top_test.sv
